@@ hw/rtl/mfw_pkg.sv @@
package mfw_pkg;

  // sizing limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 3;

  // register field widths
  localparam int W_W   = 11;
  localparam int H_W   = 13;
  localparam int R_W   = 2;
  localparam int PIX_W = 8;

  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int RR_W   = H_W + 2;
  localparam int CC_W   = COL_W + 2;

  // sample history: span of one full window plus lookahead slack
  localparam int LS_SPAN = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int LS_AW   = $clog2(LS_SPAN + 8);
  localparam int OFF_W   = LS_AW;

  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int SIDE_W   = $clog2(SIDE_MAX + 1);
  localparam int WIN_MAX  = SIDE_MAX * SIDE_MAX;
  localparam int WIN_AW   = $clog2(WIN_MAX);
  localparam int NCNT_W   = $clog2(WIN_MAX + 1);

  localparam int T_W = $clog2(MAX_WIDTH * (2 ** H_W - 1)
                              + MAX_RADIUS * (MAX_WIDTH + 1) + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [EW_W-1:0]  w;
    logic [H_W-1:0]   h;
    logic [RAD_W-1:0] rad;
    logic [OFF_W-1:0] lat;
  } geom_t;

  typedef struct packed {
    logic             has_out;
    logic             last;
    logic [LS_AW-1:0] wp;
    logic [H_W-1:0]   r0;
    logic [COL_W-1:0] c0;
  } job_t;

endpackage

@@ hw/rtl/mfw_line_ram.sv @@
module mfw_line_ram #(
  parameter int DW = 8,
  parameter int AW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hw/rtl/mfw_queue.sv @@
module mfw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfw_pkg::job_t job_i,
  input  logic          pop_i,
  output mfw_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);
  import mfw_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ hw/rtl/mfw_front.sv @@
module mfw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mfw_pkg::W_W-1:0]      width_i,
  input  logic [mfw_pkg::H_W-1:0]      height_i,
  input  logic [mfw_pkg::R_W-1:0]      radius_i,
  input  logic                         cfg_wr_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [mfw_pkg::PIX_W-1:0]    pixel_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mfw_pkg::job_t                job_o,
  output mfw_pkg::geom_t               geom_o,
  output logic                         we_o,
  output logic [mfw_pkg::LS_AW-1:0]    waddr_o,
  output logic [mfw_pkg::PIX_W-1:0]    wdata_o
);
  import mfw_pkg::*;

  logic [EW_W-1:0]  w_eff;
  logic [H_W-1:0]   h_eff;
  logic [RAD_W-1:0] rad_eff;

  logic [1:0]       settle_q, settle_d;
  geom_t            geom_q;
  logic [T_W-1:0]   total_q, t_end_q;
  logic [T_W-1:0]   t_q, t_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [H_W-1:0]   row_q, row_d;
  logic [LS_AW-1:0] wp_q;
  logic             acc, has_out, last;

  always_comb begin
    if (width_i == '0)                 w_eff = EW_W'(1);
    else if (int'(width_i) > MAX_WIDTH) w_eff = EW_W'(MAX_WIDTH);
    else                               w_eff = EW_W'(width_i);
    h_eff = (height_i == '0) ? H_W'(1) : height_i;
    rad_eff = (int'(radius_i) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_i);
  end

  // geometry pipeline: products are registered first, the end index in the cycle after
  always_ff @(posedge clk_i) begin
    geom_q.w   <= w_eff;
    geom_q.h   <= h_eff;
    geom_q.rad <= rad_eff;
    geom_q.lat <= OFF_W'(rad_eff * (w_eff + EW_W'(1)));
    total_q    <= T_W'(w_eff * h_eff);
    t_end_q    <= total_q + T_W'(geom_q.lat) - T_W'(1);
  end

  assign geom_o     = geom_q;
  assign in_stall_o = q_full_i || (settle_q != 2'd0);
  assign acc        = in_valid_i && !in_stall_o;
  assign has_out    = (t_q >= T_W'(geom_q.lat));
  assign last       = (t_q == t_end_q);

  assign we_o    = acc && (t_q < total_q);
  assign waddr_o = wp_q;
  assign wdata_o = mode_i ? '0 : pixel_i;

  assign push_o       = acc;
  assign job_o.has_out = has_out;
  assign job_o.last    = last;
  assign job_o.wp      = wp_q;
  assign job_o.r0      = row_q;
  assign job_o.c0      = col_q;

  always_comb begin
    settle_d = (settle_q != 2'd0) ? settle_q - 2'd1 : 2'd0;
    t_d   = t_q;
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr_i) begin
      settle_d = 2'd2;
      t_d   = '0;
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (last) begin
        t_d   = '0;
        col_d = '0;
        row_d = '0;
      end else begin
        t_d = t_q + T_W'(1);
        if (has_out) begin
          if (EW_W'(col_q) + EW_W'(1) >= geom_q.w) begin
            col_d = '0;
            row_d = row_q + H_W'(1);
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd2;
      t_q      <= '0;
      col_q    <= '0;
      row_q    <= '0;
      wp_q     <= '0;
    end else begin
      settle_q <= settle_d;
      t_q      <= t_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (acc) wp_q <= wp_q + LS_AW'(1);
    end
  end

endmodule

@@ hw/rtl/mfw_back.sv @@
module mfw_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfw_pkg::geom_t            geom_i,
  input  logic                      q_empty_i,
  input  mfw_pkg::job_t             q_job_i,
  output logic                      q_pop_o,
  output logic                      rd_en_o,
  output logic [mfw_pkg::LS_AW-1:0] raddr_o,
  input  logic [mfw_pkg::PIX_W-1:0] rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mfw_pkg::PIX_W-1:0] filtered_o,
  output logic                      frame_end_o
);
  import mfw_pkg::*;

  back_state_e       state_q, state_d;
  logic [LS_AW-1:0]  wp_q, wp_d;
  logic [COL_W-1:0]  c0_q, c0_d;
  logic              last_q, last_d;
  logic [RR_W-1:0]   rr_q, rr_d;
  logic [CC_W-1:0]   cc_q, cc_d;
  logic [SIDE_W-1:0] dcn_q, dcn_d, drn_q, drn_d, side_end;
  logic [OFF_W-1:0]  off_q, off_d, rowoff_q, rowoff_d;
  logic              rd_vld_q, rd_vld_d;
  logic [NCNT_W-1:0] n_q, n_d;
  logic [PIX_W-1:0]  win_q [WIN_MAX];
  logic [PIX_W-1:0]  win_ins [WIN_MAX];
  logic [WIN_MAX-1:0] gt;
  logic              inframe, out_free, load_out;
  logic              out_valid_q;
  logic [PIX_W-1:0]  out_data_q;
  logic              out_last_q;

  assign side_end = SIDE_W'({geom_i.rad, 1'b0});
  assign inframe  = !rr_q[RR_W-1] && (rr_q < RR_W'(geom_i.h))
                 && !cc_q[CC_W-1] && (cc_q < CC_W'(geom_i.w));
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_en_o  = (state_q == BK_SCAN) && inframe;
  assign raddr_o  = wp_q - LS_AW'(off_q);

  // insertion sorter: a slot past the fill count counts as greater
  for (genvar i = 0; i < WIN_MAX; i++) begin : g_sort
    assign gt[i] = (NCNT_W'(i) >= n_q) || (win_q[i] > rdata_i);
    if (i == 0) begin : g_head
      assign win_ins[i] = gt[i] ? rdata_i : win_q[i];
    end else begin : g_body
      assign win_ins[i] = !gt[i] ? win_q[i] : (gt[i-1] ? win_q[i-1] : rdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int i = 0; i < WIN_MAX; i++) win_q[i] <= win_ins[i];
    end
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    c0_d     = c0_q;
    last_d   = last_q;
    rr_d     = rr_q;
    cc_d     = cc_q;
    dcn_d    = dcn_q;
    drn_d    = drn_q;
    off_d    = off_q;
    rowoff_d = rowoff_q;
    rd_vld_d = 1'b0;
    n_d      = rd_vld_q ? n_q + NCNT_W'(1) : n_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_job_i.has_out) begin
            wp_d     = q_job_i.wp;
            c0_d     = q_job_i.c0;
            last_d   = q_job_i.last;
            rr_d     = RR_W'(q_job_i.r0) - RR_W'(geom_i.rad);
            cc_d     = CC_W'(q_job_i.c0) - CC_W'(geom_i.rad);
            dcn_d    = '0;
            drn_d    = '0;
            off_d    = OFF_W'({geom_i.lat, 1'b0});
            rowoff_d = OFF_W'({geom_i.lat, 1'b0});
            n_d      = '0;
            state_d  = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        rd_vld_d = inframe;
        if (dcn_q == side_end) begin
          if (drn_q == side_end) begin
            state_d = BK_FLUSH;
          end else begin
            drn_d    = drn_q + SIDE_W'(1);
            dcn_d    = '0;
            rr_d     = rr_q + RR_W'(1);
            cc_d     = CC_W'(c0_q) - CC_W'(geom_i.rad);
            rowoff_d = rowoff_q - OFF_W'(geom_i.w);
            off_d    = rowoff_q - OFF_W'(geom_i.w);
          end
        end else begin
          dcn_d = dcn_q + SIDE_W'(1);
          cc_d  = cc_q + CC_W'(1);
          off_d = off_q - OFF_W'(1);
        end
      end
      BK_FLUSH: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    wp_q     <= wp_d;
    c0_q     <= c0_d;
    last_q   <= last_d;
    rr_q     <= rr_d;
    cc_q     <= cc_d;
    dcn_q    <= dcn_d;
    drn_q    <= drn_d;
    off_q    <= off_d;
    rowoff_q <= rowoff_d;
    if (load_out) begin
      out_data_q <= (n_q == '0) ? '0 : win_q[WIN_AW'(n_q >> 1)];
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_vld_q    <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      n_q      <= n_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_data_q;
  assign frame_end_o = out_last_q;

endmodule

@@ hw/rtl/median_filter_window_top.sv @@
// Streaming 2-D median filter over one 8-bit raster channel, window side
// 2*radius+1. Send the frame's pixels in raster order (mode 0), then
// radius*(width+1) drain transfers (mode 1) to flush the last results; a
// result transfer leaves for every input transfer past the first
// radius*(width+1) of the frame, and frame_end marks the last pixel's
// result. Only window samples inside the frame are ranked; the result is
// the upper median of them. Input transfers are taken one per clock until
// the two-entry job queue fills; each result then needs a scan of all
// (2*radius+1)^2 window positions by the ranking engine, which reads one
// stored sample per clock from the single-read-port sample RAM. A transfer
// that yields no result is popped without a scan. Registers (APB, byte
// offsets 0x0 width, 0x4 height, 0x8 radius) may only be written while
// idle; a write restarts the frame and holds stall while the geometry
// settles. No memory clearing is needed after reset.
module median_filter_window_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfw_pkg::PADDR_W-1:0]   paddr,
  input  logic [mfw_pkg::PDATA_W-1:0]   pwdata,
  output logic [mfw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [mfw_pkg::PIX_W-1:0]     pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mfw_pkg::PIX_W-1:0]     filtered_o,
  output logic                          frame_end_o
);
  import mfw_pkg::*;

  logic [W_W-1:0] width_q;
  logic [H_W-1:0] height_q;
  logic [R_W-1:0] radius_q;
  cfg_reg_e       reg_sel;
  logic           apb_wr, cfg_wr;

  // front to queue / back
  job_t             push_job, pop_job;
  logic             q_push, q_pop, q_full, q_empty;
  geom_t            geom;
  logic             ram_we, ram_re;
  logic [LS_AW-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  // ---- register file ----
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign apb_wr  = psel && penable && pwrite;
  // a write to an unmapped offset is dropped and does not restart the frame
  assign cfg_wr  = apb_wr && (reg_sel == REG_WIDTH || reg_sel == REG_HEIGHT
                              || reg_sel == REG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_W'(640);
      height_q <= H_W'(480);
      radius_q <= R_W'(1);
    end else if (apb_wr) begin
      case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[W_W-1:0];
        REG_HEIGHT: height_q <= pwdata[H_W-1:0];
        REG_RADIUS: radius_q <= pwdata[R_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = PDATA_W'(width_q);
      REG_HEIGHT: prdata = PDATA_W'(height_q);
      REG_RADIUS: prdata = PDATA_W'(radius_q);
      default:    prdata = '0;
    endcase
  end

  // ---- front: accepts transfers, stores samples, posts jobs ----
  mfw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .radius_i   (radius_q),
    .cfg_wr_i   (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .pixel_i    (pixel_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job),
    .geom_o     (geom),
    .we_o       (ram_we),
    .waddr_o    (ram_waddr),
    .wdata_o    (ram_wdata)
  );

  // sample history, addressed by a free-running transfer index
  mfw_line_ram #(
    .DW (PIX_W),
    .AW (LS_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // every accepted transfer posts a job, so the front runs at most two
  // transfers ahead of the ranking engine and never overwrites live samples
  mfw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .job_o   (pop_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // ---- back: window scan, insertion sort, result register ----
  mfw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .q_empty_i   (q_empty),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .rd_en_o     (ram_re),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .frame_end_o (frame_end_o)
  );

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job posted into a full queue");

  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input taken before geometry settled");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");
`endif

endmodule

@@ test/tb_median_filter_window_top.sv @@
module tb_median_filter_window_top;
  import mfw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } median_out_t;

  // DUT ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               mode_i = 1'b0;
  logic [PIX_W-1:0]   pixel_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PIX_W-1:0]   filtered_o;
  logic               frame_end_o;

  // mirror of the block's state
  logic [PIX_W-1:0] pixel_hist [LS_SPAN];
  logic [W_W-1:0]   width_reg;
  logic [H_W-1:0]   height_reg;
  logic [R_W-1:0]   radius_reg;
  int unsigned      frame_item_cnt;
  int unsigned      out_col;
  int unsigned      out_row;

  median_out_t medians_pending[$];
  int          fail_cnt = 0;
  int          items_sent = 0;

  // idle percentages and receiver hold-off, shared with the test tasks
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_left = 0;

  // values sampled mid-cycle so edge decisions never race the DUT
  logic in_stall_s, out_valid_s, out_stall_s, frame_end_s;
  logic [PIX_W-1:0] filtered_s;

  median_filter_window_top i_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    in_stall_s  = in_stall_o;
    out_valid_s = out_valid_o;
    out_stall_s = out_stall_i;
    filtered_s  = filtered_o;
    frame_end_s = frame_end_o;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int unsigned eff_radius();
    return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
  endfunction

  // Push the expected median for one accepted transfer, if it yields one.
  task automatic predict_median(input logic mode, input logic [PIX_W-1:0] pix);
    int unsigned ew, eh, er, total, lat, t, n, j;
    int          rr, cc;
    logic [PIX_W-1:0] win [WIN_MAX];
    logic [PIX_W-1:0] v;
    median_out_t res;
    ew = eff_width();
    eh = eff_height();
    er = eff_radius();
    total = ew * eh;
    lat = er * (ew + 1);
    t = frame_item_cnt;
    // a drain among frame pixels stores zero
    if (t < total) pixel_hist[t % LS_SPAN] = mode ? '0 : pix;
    frame_item_cnt = t + 1;
    if (t < lat) return;
    n = 0;
    for (int dr = -int'(er); dr <= int'(er); dr++) begin
      rr = int'(out_row) + dr;
      if (rr < 0 || rr >= int'(eh)) continue;
      for (int dc = -int'(er); dc <= int'(er); dc++) begin
        cc = int'(out_col) + dc;
        if (cc < 0 || cc >= int'(ew)) continue;
        win[n] = pixel_hist[(rr * ew + cc) % LS_SPAN];
        n++;
      end
    end
    for (int i = 1; i < n; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && win[j-1] > v) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = v;
    end
    res.filtered  = win[n/2];
    res.frame_end = ((t - lat) == total - 1);
    medians_pending.insert(medians_pending.size(), res);
    out_col++;
    if (out_col >= ew) begin
      out_col = 0;
      out_row = (out_row + 1) & 13'h1fff;
    end
    if (res.frame_end) begin
      frame_item_cnt = 0;
      out_col = 0;
      out_row = 0;
    end
  endtask

  // Receiver: checks each result transfer, then drives stall for the next cycle.
  always @(posedge clk_i) begin
    median_out_t exp_res;
    if (rst_ni && out_valid_s && !out_stall_s) begin
      if (medians_pending.size() == 0) begin
        $error("unexpected result transfer: filtered=%0d frame_end=%0d",
               filtered_s, frame_end_s);
        fail_cnt++;
      end else begin
        exp_res = medians_pending.pop_front();
        if (filtered_s !== exp_res.filtered) begin
          $error("filtered: expected %0d, got %0d", exp_res.filtered, filtered_s);
          fail_cnt++;
        end
        if (frame_end_s !== exp_res.frame_end) begin
          $error("frame_end: expected %0d, got %0d", exp_res.frame_end, frame_end_s);
          fail_cnt++;
        end
      end
    end
    // long hold-off counts down here; otherwise random stall
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // One input transfer; valid stays high on return so back-to-back items
  // never see valid dropped and raised in the same step.
  task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    pixel_i    <= pix;
    do @(posedge clk_i); while (in_stall_s);
    predict_median(mode, pix);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result is back, then let the
  // ranking engine finish any work that yields no result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (medians_pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // APB write: setup, access; register lands on the access edge.
  task automatic cfg_write(input cfg_reg_e idx, input int unsigned val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg  = val[W_W-1:0];
      REG_HEIGHT: height_reg = val[H_W-1:0];
      REG_RADIUS: radius_reg = val[R_W-1:0];
      default: ;
    endcase
    frame_item_cnt = 0;
    out_col = 0;
    out_row = 0;
  endtask

  function automatic logic [PIX_W-1:0] rand_pix();
    // narrow range half the time so ties show up in the ranking
    return $urandom_range(1) ? PIX_W'($urandom_range(3)) : PIX_W'($urandom_range(255));
  endfunction

  // Configure and stream one frame. noise_pct flips the mode of pixels and
  // drains; cut stops halfway through the pixels to leave a frame pending.
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned r, input int noise_pct,
                            input bit cut, input int fill);
    int unsigned n_pix, n_drain;
    logic [PIX_W-1:0] pix;
    drain_results();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_RADIUS, r);
    n_pix   = eff_width() * eff_height();
    n_drain = eff_radius() * (eff_width() + 1);
    if (cut) n_pix = n_pix / 2;
    for (int unsigned i = 0; i < n_pix; i++) begin
      case (fill)
        1:       pix = '1;
        2:       pix = '0;
        3:       pix = (i % 2) ? '1 : '0;
        default: pix = rand_pix();
      endcase
      send_item($urandom_range(99) < noise_pct, pix);
    end
    if (cut) return;
    // a pixel sent past the frame is treated as a drain
    for (int unsigned i = 0; i < n_drain; i++)
      send_item(!($urandom_range(99) < noise_pct), rand_pix());
  endtask

  task automatic test_window_extremes();
    send_frame(3, 3, 1, 0, 0, 3);
    send_frame(7, 7, 3, 0, 0, 1);
    send_frame(4, 2, 0, 0, 0, 2);
    send_frame(3, 2, 2, 0, 0, 0);
    send_frame(5, 3, 1, 30, 0, 0);
  endtask

  task automatic test_geometry_saturation();
    send_frame(0, 0, 3, 0, 0, 0);
    send_frame(0, 6, 1, 0, 0, 0);
    send_frame(2, 0, 2, 0, 0, 0);
  endtask

  task automatic test_midframe_restart();
    send_frame(6, 5, 2, 0, 1, 0);
    send_frame(6, 5, 2, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_left = 400;
    send_frame(16, 6, 2, 0, 0, 0);
  endtask

  task automatic test_random_frames(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      send_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3),
                 $urandom_range(3) == 0 ? 10 : 0, $urandom_range(19) == 0, 0);
    end
  endtask

  initial begin
    width_reg  = 640;
    height_reg = 480;
    radius_reg = 1;
    frame_item_cnt = 0;
    out_col = 0;
    out_row = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct = 26;
    out_idle_pct = 60;
    test_window_extremes();
    test_geometry_saturation();
    test_midframe_restart();
    test_backpressure();
    test_random_frames(150);
    in_idle_pct = 60;
    out_idle_pct = 26;
    test_random_frames(150);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_frames(150);

    drain_results();
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #30ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
